/* sv/axclp_pkg.sv */
// shared constants and types for the command line parser
`timescale 1ns / 1ps
`default_nettype none

package axclp_pkg;

	// accumulator width default
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// coordinate field width on the result beat
	localparam int unsigned COORD_W = 16;

	// beat widths
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 40;

	// result beat bit positions
	localparam int unsigned OUT_HAS_X_B  = 0;
	localparam int unsigned OUT_X_LSB    = 1;
	localparam int unsigned OUT_HAS_Y_B  = 17;
	localparam int unsigned OUT_Y_LSB    = 18;
	localparam int unsigned OUT_HAS_M_B  = 34;
	localparam int unsigned OUT_MAG_ON_B = 35;
	localparam int unsigned OUT_HAS_B_B  = 36;
	localparam int unsigned OUT_BELT_LSB = 37;

	// ascii codes
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X_UC  = 8'h58;
	localparam logic [7:0] CH_X_LC  = 8'h78;
	localparam logic [7:0] CH_Y_UC  = 8'h59;
	localparam logic [7:0] CH_Y_LC  = 8'h79;
	localparam logic [7:0] CH_M_UC  = 8'h4d;
	localparam logic [7:0] CH_M_LC  = 8'h6d;
	localparam logic [7:0] CH_B_UC  = 8'h42;
	localparam logic [7:0] CH_B_LC  = 8'h62;

	// belt modes
	typedef enum logic [1:0] {
		BELT_STOP = 2'd0,
		BELT_FWD  = 2'd1,
		BELT_BWD  = 2'd2
	} belt_t;

	// one parsed command
	typedef struct packed {
		logic               has_x;
		logic [COORD_W-1:0] x_value;
		logic               has_y;
		logic [COORD_W-1:0] y_value;
		logic               has_magnet;
		logic               magnet_en;
		logic               has_belt;
		belt_t              belt_mode;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/axis_command_line_parser.sv */
// command line parser: ascii byte stream in, parsed motion commands out
//
// usage
//   slave side takes one ascii character per beat in s_axis_tdata; words are
//   X, Y, M or B (either case) followed by decimal digits, separated by spaces,
//   and a line ends with CR, LF or ';'
//   master side gives one beat per terminated line that carried at least one
//   good word; bad lines and empty lines give no beat
//   path: an accepted terminator goes through the input register, then one
//   pass of parse logic into the result register, which shows its beat
//   throughput: one character per cycle while the result side is not stalled;
//   every character takes exactly one pass, the loop is the parser state update
//   stall: the result register holds while m_axis_tready is low; the input
//   register keeps taking one more character, then s_axis_tready drops until
//   the result beat leaves
//   reset: arst_n low clears both valid flags, the parse mode and the pending
//   command; the accumulator saturates at 2^VALUE_WIDTH - 1
`timescale 1ns / 1ps
`default_nettype none

module axis_command_line_parser #(
	parameter int unsigned VALUE_WIDTH = axclp_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// slave side
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [axclp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // byte_in[7:0]
	// master side
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// has_x, x_value[15:0], has_y, y_value[15:0], has_magnet, magnet_en,
	// has_belt, belt_mode[1:0], one zero pad bit
	output logic [axclp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	import axclp_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_X,
		MODE_Y,
		MODE_M,
		MODE_B,
		MODE_BAD
	} mode_t;

	localparam int unsigned MUL_W = VALUE_WIDTH + 4;
	localparam logic [VALUE_WIDTH-1:0] ACC_MAX = {VALUE_WIDTH{1'b1}};

	// input register
	logic [7:0] byte_s1;
	logic       valid_s1;

	// parser state
	mode_t                  mode_q, mode_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	cmd_t                   pend_q, pend_d;

	// result register
	logic m_valid_q;

	logic advance;
	logic emit;
	cmd_t closed;
	cmd_t empty_cmd;
	logic is_term, is_digit, is_space, is_x, is_y, is_m, is_b;
	logic in_word;
	logic [MUL_W-1:0] acc_ext, acc_mul;
	mode_t letter_mode;

	// the parse pass runs whenever the result slot is free or draining
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;

	assign empty_cmd = '0;

	// byte classes
	assign is_term  = (byte_s1 == CH_CR) || (byte_s1 == CH_LF) || (byte_s1 == CH_SEMI);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_space = (byte_s1 == CH_SPACE);
	assign is_x     = (byte_s1 == CH_X_UC) || (byte_s1 == CH_X_LC);
	assign is_y     = (byte_s1 == CH_Y_UC) || (byte_s1 == CH_Y_LC);
	assign is_m     = (byte_s1 == CH_M_UC) || (byte_s1 == CH_M_LC);
	assign is_b     = (byte_s1 == CH_B_UC) || (byte_s1 == CH_B_LC);
	assign in_word  = (mode_q == MODE_X) || (mode_q == MODE_Y) ||
	                  (mode_q == MODE_M) || (mode_q == MODE_B);

	// acc * 10 + digit, saturated below
	assign acc_ext = MUL_W'(acc_q);
	assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + MUL_W'(byte_s1[3:0]);

	always_comb begin
		if (is_x) begin
			letter_mode = MODE_X;
		end else if (is_y) begin
			letter_mode = MODE_Y;
		end else if (is_m) begin
			letter_mode = MODE_M;
		end else begin
			letter_mode = MODE_B;
		end
	end

	// pending command with the current word folded in
	always_comb begin
		closed = pend_q;
		unique case (mode_q)
			MODE_X: begin
				closed.has_x   = 1'b1;
				closed.x_value = COORD_W'(acc_q);
			end
			MODE_Y: begin
				closed.has_y   = 1'b1;
				closed.y_value = COORD_W'(acc_q);
			end
			MODE_M: begin
				closed.has_magnet = 1'b1;
				closed.magnet_en  = (acc_q != '0);
			end
			MODE_B: begin
				closed.has_belt = 1'b1;
				if (acc_q == '0) begin
					closed.belt_mode = BELT_STOP;
				end else if (acc_q == VALUE_WIDTH'(1)) begin
					closed.belt_mode = BELT_FWD;
				end else begin
					closed.belt_mode = BELT_BWD;
				end
			end
			default: begin
				closed = pend_q;
			end
		endcase
	end

	// one parse step
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		pend_d = pend_q;
		emit   = 1'b0;
		if (is_term) begin
			emit   = closed.has_x || closed.has_y || closed.has_magnet || closed.has_belt;
			pend_d = empty_cmd;
			mode_d = MODE_IDLE;
		end else if (mode_q == MODE_BAD) begin
			mode_d = MODE_BAD;
		end else if (is_digit) begin
			if (in_word) begin
				acc_d = (acc_mul[MUL_W-1:VALUE_WIDTH] != '0) ? ACC_MAX :
				        acc_mul[VALUE_WIDTH-1:0];
			end else begin
				mode_d = MODE_BAD;
				pend_d = empty_cmd;
			end
		end else if (is_x || is_y || is_m || is_b) begin
			if (mode_q == MODE_IDLE) begin
				acc_d  = '0;
				mode_d = letter_mode;
			end else begin
				mode_d = MODE_BAD;
				pend_d = empty_cmd;
			end
		end else if (is_space) begin
			pend_d = closed;
			mode_d = MODE_IDLE;
		end else begin
			// any other character spoils the line
			mode_d = MODE_BAD;
			pend_d = empty_cmd;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			mode_q    <= MODE_IDLE;
			acc_q     <= '0;
			pend_q    <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				mode_q    <= mode_d;
				acc_q     <= acc_d;
				pend_q    <= pend_d;
				m_valid_q <= emit;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && emit) begin
			m_axis_tdata <= {1'b0, closed.belt_mode, closed.has_belt, closed.magnet_en,
			                 closed.has_magnet, closed.y_value, closed.has_y,
			                 closed.x_value, closed.has_x};
		end
	end

endmodule

`default_nettype wire

/* sv/axclp_checker.sv */
// port-level checks for the command line parser, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module axclp_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [axclp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [axclp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	import axclp_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// a new result follows an accepted input beat, through the input and result registers
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result beat without a matching input beat");

	// a ready receiver never blocks the input side
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side is ready");

	// every emitted command carries a word and a legal belt mode
	a_out_content: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_HAS_X_B] || m_axis_tdata[OUT_HAS_Y_B] ||
		                   m_axis_tdata[OUT_HAS_M_B] || m_axis_tdata[OUT_HAS_B_B]) &&
		                  (m_axis_tdata[OUT_BELT_LSB +: 2] != 2'b11))
		else $error("empty command or bad belt mode on result beat");

	// absent fields read as zero
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_HAS_X_B] || m_axis_tdata[OUT_X_LSB +: COORD_W] == '0) &&
		                  (m_axis_tdata[OUT_HAS_Y_B] || m_axis_tdata[OUT_Y_LSB +: COORD_W] == '0) &&
		                  (m_axis_tdata[OUT_HAS_M_B] || !m_axis_tdata[OUT_MAG_ON_B]))
		else $error("absent field not zero on result beat");

endmodule

bind axis_command_line_parser axclp_checker u_axclp_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// testbench for the command line parser: directed lines, random lines, checked per beat
`timescale 1ns / 1ps

module tb;
	import axclp_pkg::*;

	localparam int VW           = VALUE_WIDTH_DEF;
	localparam int TOTAL_CHARS  = 1150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_DIR        = 8;

	// how a directed row gets its expectation
	typedef enum int {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_TYPED
	} row_kind_t;

	// parser position within a line
	typedef enum logic [2:0] {
		PS_IDLE,
		PS_X,
		PS_Y,
		PS_M,
		PS_B,
		PS_BAD
	} parse_state_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	axis_command_line_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted parser state
	parse_state_t   parse_st;
	logic [VW-1:0]  acc_value;
	logic           pend_has_x;
	logic [VW-1:0]  pend_x;
	logic           pend_has_y;
	logic [VW-1:0]  pend_y;
	logic           pend_has_mag;
	logic           pend_mag_on;
	logic           pend_has_belt;
	belt_t          pend_belt;

	cmd_t parsed_cmds_q[$];

	int  chars_sent   = 0;
	int  lines_sent   = 0;
	int  cmds_checked = 0;
	int  mismatches   = 0;
	int  cycle_count  = 0;
	int  input_stalls = 0;
	bit  no_gaps      = 1'b0;
	bit  hold_req     = 1'b0;

	logic [7:0] word_letters [8] = '{CH_X_UC, CH_X_LC, CH_Y_UC, CH_Y_LC,
		CH_M_UC, CH_M_LC, CH_B_UC, CH_B_LC};
	logic [7:0] line_ends [3] = '{CH_CR, CH_LF, CH_SEMI};

	// directed lines; a tilde stands for a nul byte
	string     dir_text [N_DIR] = '{
		"\n",          // lone terminator
		"X99999;",     // saturates at the top of the range
		"y0 m1 b2\r",  // zero coordinate, magnet on, belt backward
		"b M0;",       // letter with no digits, magnet off
		"7;",          // digit outside a word
		"XY;",         // letter inside a word
		"~\377 x5\n",  // nul and 0xff bytes, rest of the bad line ignored
		"m7 Y\n"
	};
	row_kind_t dir_kind [N_DIR] = '{ROW_SILENT, ROW_TYPED, ROW_TYPED, ROW_TYPED,
		ROW_SILENT, ROW_SILENT, ROW_SILENT, ROW_PREDICT};
	cmd_t      dir_cmd [N_DIR];

	function automatic cmd_t mk_cmd(input logic hx, input logic [15:0] xv,
		input logic hy, input logic [15:0] yv, input logic hm, input logic mo,
		input logic hb, input belt_t bm);
		cmd_t c;
		c.has_x      = hx;
		c.x_value    = xv;
		c.has_y      = hy;
		c.y_value    = yv;
		c.has_magnet = hm;
		c.magnet_en  = mo;
		c.has_belt   = hb;
		c.belt_mode  = bm;
		return c;
	endfunction

	function void clear_pending();
		pend_has_x    = 1'b0;
		pend_x        = '0;
		pend_has_y    = 1'b0;
		pend_y        = '0;
		pend_has_mag  = 1'b0;
		pend_mag_on   = 1'b0;
		pend_has_belt = 1'b0;
		pend_belt     = BELT_STOP;
	endfunction

	// a finished word lands in its slot of the pending command
	function void close_word();
		case (parse_st)
			PS_X: begin
				pend_has_x = 1'b1;
				pend_x     = acc_value;
			end
			PS_Y: begin
				pend_has_y = 1'b1;
				pend_y     = acc_value;
			end
			PS_M: begin
				pend_has_mag = 1'b1;
				pend_mag_on  = (acc_value != 0);
			end
			PS_B: begin
				pend_has_belt = 1'b1;
				pend_belt     = (acc_value == 0) ? BELT_STOP :
					(acc_value == 1) ? BELT_FWD : BELT_BWD;
			end
			default: ;
		endcase
	endfunction

	function void start_word(input parse_state_t next_st);
		if (parse_st != PS_IDLE) begin
			parse_st = PS_BAD;
		end else begin
			acc_value = '0;
			parse_st  = next_st;
		end
	endfunction

	// one character through the predicted parser
	function void parse_char(input logic [7:0] ch, output bit emitted, output cmd_t cmd);
		logic [VW+4:0] grown;
		emitted = 1'b0;
		cmd     = '0;
		if (ch == CH_CR || ch == CH_LF || ch == CH_SEMI) begin
			close_word();
			if (pend_has_x || pend_has_y || pend_has_mag || pend_has_belt) begin
				cmd = mk_cmd(pend_has_x, pend_x[COORD_W-1:0], pend_has_y,
					pend_y[COORD_W-1:0], pend_has_mag, pend_mag_on, pend_has_belt,
					pend_belt);
				emitted = 1'b1;
				clear_pending();
			end
			parse_st = PS_IDLE;
			return;
		end
		if (parse_st == PS_BAD)
			return;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (parse_st inside {PS_X, PS_Y, PS_M, PS_B}) begin
				grown = (VW+5)'({5'b0, acc_value} * 10 + (ch - CH_ZERO));
				acc_value = (grown > {5'b0, {VW{1'b1}}}) ? {VW{1'b1}} : grown[VW-1:0];
			end else begin
				parse_st = PS_BAD;
			end
		end else if (ch == CH_X_UC || ch == CH_X_LC) begin
			start_word(PS_X);
		end else if (ch == CH_Y_UC || ch == CH_Y_LC) begin
			start_word(PS_Y);
		end else if (ch == CH_M_UC || ch == CH_M_LC) begin
			start_word(PS_M);
		end else if (ch == CH_B_UC || ch == CH_B_LC) begin
			start_word(PS_B);
		end else if (ch == CH_SPACE) begin
			close_word();
			parse_st = PS_IDLE;
		end else begin
			parse_st = PS_BAD;
		end
		if (parse_st == PS_BAD)
			clear_pending();
	endfunction

	function void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("command %0d: %s expected %0d, got %0d", cmds_checked, name,
					want, got);
		end
	endfunction

	// one byte over the slave side, then into the predictor once it is taken
	task automatic send_char(input logic [7:0] ch, input bit use_model);
		int   gap;
		bit   emitted;
		cmd_t cmd;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		do @(posedge clk); while (!s_axis_tready);
		parse_char(ch, emitted, cmd);
		if (use_model && emitted)
			parsed_cmds_q.push_back(cmd);
		chars_sent++;
	endtask

	// watchdog and stall count
	always @(posedge clk) begin
		cycle_count++;
		if (s_axis_tvalid && !s_axis_tready)
			input_stalls++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding", cycle_count,
				parsed_cmds_q.size());
			$display("** axis_command_line_parser: FAILED **");
			$finish;
		end
	end

	// master side: random stalls, one long hold-off on request, check each beat
	initial begin
		int   stall;
		cmd_t got;
		cmd_t want;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = no_gaps ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.has_x      = m_axis_tdata[OUT_HAS_X_B];
			got.x_value    = m_axis_tdata[OUT_X_LSB +: COORD_W];
			got.has_y      = m_axis_tdata[OUT_HAS_Y_B];
			got.y_value    = m_axis_tdata[OUT_Y_LSB +: COORD_W];
			got.has_magnet = m_axis_tdata[OUT_HAS_M_B];
			got.magnet_en  = m_axis_tdata[OUT_MAG_ON_B];
			got.has_belt   = m_axis_tdata[OUT_HAS_B_B];
			got.belt_mode  = belt_t'(m_axis_tdata[OUT_BELT_LSB +: 2]);
			if (parsed_cmds_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected command beat %h", m_axis_tdata);
			end else begin
				want = parsed_cmds_q.pop_front();
				check_field("has_x", want.has_x, got.has_x);
				check_field("x_value", want.x_value, got.x_value);
				check_field("has_y", want.has_y, got.has_y);
				check_field("y_value", want.y_value, got.y_value);
				check_field("has_magnet", want.has_magnet, got.has_magnet);
				check_field("magnet_en", want.magnet_en, got.magnet_en);
				check_field("has_belt", want.has_belt, got.has_belt);
				check_field("belt_mode", want.belt_mode, got.belt_mode);
			end
			cmds_checked++;
		end
	end

	// slave side: reset, directed lines, then random lines
	initial begin
		logic [7:0] ch;
		logic [7:0] line_buf[$];
		int         kind;
		int         n_words;
		int         n_digits;
		int         idx;
		int         pos;
		bit         hold_done;
		hold_done = 1'b0;
		dir_cmd[0] = '0;
		dir_cmd[1] = mk_cmd(1'b1, 16'hffff, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, BELT_STOP);
		dir_cmd[2] = mk_cmd(1'b0, 16'd0, 1'b1, 16'd0, 1'b1, 1'b1, 1'b1, BELT_BWD);
		dir_cmd[3] = mk_cmd(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b1, BELT_STOP);
		for (int r = 4; r < N_DIR; r++)
			dir_cmd[r] = '0;
		parse_st = PS_IDLE;
		acc_value = '0;
		clear_pending();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			for (int i = 0; i < dir_text[r].len(); i++) begin
				ch = (dir_text[r][i] == "~") ? 8'h00 : dir_text[r][i];
				send_char(ch, dir_kind[r] == ROW_PREDICT);
			end
			if (dir_kind[r] == ROW_TYPED)
				parsed_cmds_q.push_back(dir_cmd[r]);
			lines_sent++;
		end

		// mostly well-formed lines, some empty, broken or pure noise
		while (chars_sent < TOTAL_CHARS) begin
			if (lines_sent % 20 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if (!hold_done && chars_sent >= 500) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			line_buf.delete();
			kind = $urandom_range(0, 99);
			n_words = (kind < 70 || (kind >= 78 && kind < 90)) ? $urandom_range(1, 4) : 0;
			if (kind >= 70 && kind < 78)
				repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
			if (kind >= 90)
				repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
			for (int w = 0; w < n_words; w++) begin
				if (w > 0 || $urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
				idx = $urandom_range(0, 7);
				line_buf.push_back(word_letters[idx]);
				if (idx >= 4 && $urandom_range(0, 1) == 1) begin
					// magnet and belt words mostly carry 0, 1 or 2
					line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 2)));
				end else begin
					kind = (kind >= 78) ? kind : $urandom_range(0, 19);
					n_digits = $urandom_range(0, 19);
					n_digits = (n_digits == 0) ? 0 :
						(n_digits == 1) ? $urandom_range(6, 8) : $urandom_range(1, 5);
					repeat (n_digits) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				end
			end
			line_buf.push_back(line_ends[$urandom_range(0, 2)]);
			if (kind >= 78 && kind < 90) begin
				// corrupt one byte ahead of the terminator, in place or inserted
				pos = $urandom_range(0, line_buf.size() - 2);
				if ($urandom_range(0, 1) == 1)
					line_buf[pos] = 8'($urandom_range(0, 255));
				else
					line_buf.insert(pos, 8'($urandom_range(0, 255)));
			end
			foreach (line_buf[i])
				send_char(line_buf[i], 1'b1);
			lines_sent++;
		end
		s_axis_tvalid <= 1'b0;

		while (parsed_cmds_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d characters in %0d lines, %0d command beats compared",
			chars_sent, lines_sent, cmds_checked);
		$display("input stalled for %0d cycles, %0d mismatches", input_stalls, mismatches);
		if (mismatches == 0) begin
			$display("** axis_command_line_parser: PASSED **");
		end else begin
			$display("** axis_command_line_parser: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/axclp_pkg.sv
sv/axis_command_line_parser.sv
sv/axclp_checker.sv
verif/tb.sv
